// File: hw/rtl/acd_pkg.sv
// acd_pkg: shared types and constants for the affine cipher decrypt block
// no dependencies; imported by the interfaces, the modular unit and the top level

package acd_pkg;

  localparam int unsigned LETTER_W = 8;
  localparam int unsigned KEY_W    = 7;
  localparam int unsigned MOD_W    = 8;

  localparam logic [LETTER_W-1:0] LETTER_BASE = 8'd97;
  localparam logic [MOD_W-1:0]    MOD_RESET   = 8'd26;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_A,
    ST_SEARCH,
    ST_RED_B,
    ST_ADD_T,
    ST_MUL,
    ST_FIN
  } acd_state_t;

  // result of the shared modular add / compare-subtract unit
  typedef struct packed {
    logic [MOD_W-1:0] val;
    logic             ge;
  } acd_mod_res_t;

endpackage

// File: hw/rtl/acd_chan_if.sv
// acd_chan_if: request channels of the affine cipher decrypt block
// depends on acd_pkg for field widths

interface acd_in_if import acd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] cipher_letter;
  logic [KEY_W-1:0]    key_multiplier;
  logic [KEY_W-1:0]    key_shift;

  modport source (output valid, cipher_letter, key_multiplier, key_shift, input ready);
  modport sink   (input valid, cipher_letter, key_multiplier, key_shift, output ready);
endinterface

interface acd_out_if import acd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] plain_letter;
  logic                key_invalid;
  logic                letter_outside;

  modport source (output valid, plain_letter, key_invalid, letter_outside, input ready);
  modport sink   (input valid, plain_letter, key_invalid, letter_outside, output ready);
endinterface

// File: hw/rtl/acd_modunit.sv
// acd_modunit: shared modular add with one compare and subtract
// depends on acd_pkg; result is (x + y) reduced once by m, ge tells if it was

module acd_modunit import acd_pkg::*; (
  input  logic [MOD_W-1:0] x,
  input  logic [MOD_W-1:0] y,
  input  logic [MOD_W-1:0] m,
  output acd_mod_res_t     res
);

  logic [MOD_W:0] sum;
  logic [MOD_W:0] diff;

  always_comb begin
    sum     = {1'b0, x} + {1'b0, y};
    diff    = sum - {1'b0, m};
    res.ge  = (sum >= {1'b0, m});
    res.val = res.ge ? diff[MOD_W-1:0] : sum[MOD_W-1:0];
  end

endmodule

// File: hw/rtl/affine_cipher_decrypt_top.sv
// affine_cipher_decrypt_top: one request in, one decrypted letter out, modulus register
// steps, a = multiplier, b = shift, m = modulus >= 2: reduce a by repeated subtraction, search
//   for the inverse, reduce b, add to form t, multiply by repeated addition of t, load the output;
//   flagged requests load right after the search, m < 2 straight from idle
// a new request is taken only after the last result is loaded, which waits while the output is full
// reset: synchronous active-low rst_n; modulus returns to 26, sequencer idles, output empties

module affine_cipher_decrypt_top import acd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [MOD_W-1:0] cfg_wdata,
  acd_in_if.sink           in_ch,
  acd_out_if.source        out_ch
);

  // control state
  acd_state_t st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [MOD_W-1:0] mod_r;

  // working registers
  logic [LETTER_W-1:0] c_r, c_nxt;
  logic [KEY_W-1:0]    b_r, b_nxt;
  logic [MOD_W-1:0]    acc_r, acc_nxt;   // running residue
  logic [MOD_W-1:0]    r_r, r_nxt;       // addend: a mod m, later t
  logic [MOD_W-1:0]    i_r, i_nxt;       // search index, later multiply count
  logic [MOD_W-1:0]    inv_r, inv_nxt;
  logic                invalid_r, invalid_nxt;
  logic                outside_r, outside_nxt;

  // output payload
  logic [LETTER_W-1:0] plain_r, plain_nxt;
  logic                kinv_r, kinv_nxt;
  logic                lout_r, lout_nxt;

  // shared unit
  logic [MOD_W-1:0] ux, uy;
  acd_mod_res_t     ures;

  logic in_acc;
  logic out_free;
  logic [MOD_W-1:0] v;           // letter offset inside the alphabet
  logic [LETTER_W:0] top_lim;    // first byte past the alphabet

  acd_modunit u_mod (
    .x   (ux),
    .y   (uy),
    .m   (mod_r),
    .res (ures)
  );

  assign in_ch.ready           = (st_r == ST_IDLE);
  assign in_acc                = in_ch.valid && in_ch.ready;
  assign out_free              = !out_valid_r || out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.plain_letter   = plain_r;
  assign out_ch.key_invalid    = kinv_r;
  assign out_ch.letter_outside = lout_r;
  assign v                     = c_r - LETTER_BASE;
  assign top_lim               = {1'b0, LETTER_BASE} + {1'b0, mod_r};

  // operand select for the shared unit
  always_comb begin
    ux = acc_r;
    uy = '0;
    unique case (st_r)
      ST_SEARCH, ST_MUL: uy = r_r;
      ST_ADD_T: begin
        ux = v;
        uy = mod_r - acc_r;   // m - (b mod m); the single reduction folds m back to 0
      end
      default: uy = '0;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = (mod_r < 8'd2) ? ST_FIN : ST_RED_A;
        end
      end
      ST_RED_A: begin
        if (!ures.ge) st_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (acc_r == 8'd1) begin
          st_nxt = outside_r ? ST_FIN : ST_RED_B;
        end else if (i_r == mod_r - 8'd1) begin
          st_nxt = ST_FIN;
        end
      end
      ST_RED_B: begin
        if (!ures.ge) st_nxt = ST_ADD_T;
      end
      ST_ADD_T: st_nxt = ST_MUL;
      ST_MUL: begin
        if (i_r == '0) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    c_nxt         = c_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    r_nxt         = r_r;
    i_nxt         = i_r;
    inv_nxt       = inv_r;
    invalid_nxt   = invalid_r;
    outside_nxt   = outside_r;
    plain_nxt     = plain_r;
    kinv_nxt      = kinv_r;
    lout_nxt      = lout_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          c_nxt       = in_ch.cipher_letter;
          b_nxt       = in_ch.key_shift;
          acc_nxt     = {1'b0, in_ch.key_multiplier};
          invalid_nxt = (mod_r < 8'd2);
          outside_nxt = (in_ch.cipher_letter < LETTER_BASE) ||
                        ({1'b0, in_ch.cipher_letter} >= top_lim);
        end
      end
      ST_RED_A: begin
        if (ures.ge) begin
          acc_nxt = ures.val;
        end else begin
          r_nxt = acc_r;      // a mod m, also the product for index 1
          i_nxt = 8'd1;
        end
      end
      ST_SEARCH: begin
        if (acc_r == 8'd1) begin
          inv_nxt = i_r;
          acc_nxt = {1'b0, b_r};
        end else if (i_r == mod_r - 8'd1) begin
          invalid_nxt = 1'b1;
        end else begin
          acc_nxt = ures.val;
          i_nxt   = i_r + 8'd1;
        end
      end
      ST_RED_B: begin
        if (ures.ge) acc_nxt = ures.val;
      end
      ST_ADD_T: begin
        r_nxt   = ures.val;   // t = (v - b) mod m
        acc_nxt = '0;
        i_nxt   = inv_r;
      end
      ST_MUL: begin
        if (i_r != '0) begin
          acc_nxt = ures.val;
          i_nxt   = i_r - 8'd1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kinv_nxt      = invalid_r;
          lout_nxt      = outside_r;
          plain_nxt     = (invalid_r || outside_r) ? c_r : acc_r + LETTER_BASE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_RESET;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) mod_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    b_r       <= b_nxt;
    acc_r     <= acc_nxt;
    r_r       <= r_nxt;
    i_r       <= i_nxt;
    inv_r     <= inv_nxt;
    invalid_r <= invalid_nxt;
    outside_r <= outside_nxt;
    plain_r   <= plain_nxt;
    kinv_r    <= kinv_nxt;
    lout_r    <= lout_nxt;
  end

  // residue stays reduced while searching for the inverse
  a_search_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SEARCH) |-> (acc_r < mod_r))
    else $error("search residue not reduced");

  // repeated-add count never exceeds the inverse
  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MUL) |-> (i_r <= inv_r))
    else $error("multiply count past inverse");

  // an unflagged letter lands inside the alphabet
  a_plain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.key_invalid && !out_ch.letter_outside && mod_r <= 8'd159)
    |-> (out_ch.plain_letter >= LETTER_BASE &&
         ({1'b0, out_ch.plain_letter} < top_lim)))
    else $error("plain letter outside alphabet");

  // a loaded result reaches the output in the next cycle
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && out_free) |=> (out_valid_r && st_r == ST_IDLE))
    else $error("result not loaded");

endmodule
